// ===== hw/rtl/bqd_pkg.sv =====
// Shared widths, command codes and register indexes for the direct form II biquad.
`timescale 1ns / 1ps

package bqd_pkg;

   localparam int DATA_WIDTH  = 16;
   localparam int COEF_WIDTH  = 18;
   localparam int DELAY_FRAC  = 8;
   localparam int DELAY_WIDTH = DATA_WIDTH + DELAY_FRAC;
   localparam int COEF_FRAC   = COEF_WIDTH - 4;
   localparam int ACC_FRAC    = COEF_FRAC + DELAY_FRAC;
   localparam int PROD_WIDTH  = COEF_WIDTH + DELAY_WIDTH;
   localparam int ACC_WIDTH   = PROD_WIDTH + 2;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FB_COEF_ONE  = 3'd0,
      CSR_FB_COEF_TWO  = 3'd1,
      CSR_FF_COEF_ZERO = 3'd2,
      CSR_FF_COEF_ONE  = 3'd3,
      CSR_FF_COEF_TWO  = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD_X,
      ACC_SUB,
      ACC_ADD,
      ACC_LOAD_PROD
   } acc_op_type;

   typedef enum logic [2:0] {
      MUL_A1_S1,
      MUL_A2_S2,
      MUL_B1_S1,
      MUL_B2_S2,
      MUL_B0_P
   } mul_sel_type;

   typedef struct packed {
      acc_op_type  acc_op;
      mul_sel_type mul_sel;
      logic        capture;
      logic        latch_node;
      logic        finish;
   } bqd_cmd_type;

endpackage

// ===== hw/rtl/bqd_if.sv =====
// Valid/ready channel interfaces for the sample and result streams.
`timescale 1ns / 1ps

interface bqd_req_if import bqd_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] sample_in;
   logic                         last_in;

   modport source (output valid, output sample_in, output last_in, input ready);
   modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface bqd_rsp_if import bqd_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] sample_out;
   logic                         last_out;

   modport source (output valid, output sample_out, output last_out, input ready);
   modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface

// ===== hw/rtl/bqd_ctrl.sv =====
// Sequencer that steps the shared multiplier through the five products of one sample.
`timescale 1ns / 1ps

module bqd_ctrl import bqd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output bqd_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FB_ONE,
      ST_FB_TWO,
      ST_NODE,
      ST_FF_ONE,
      ST_FF_TWO,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.acc_op     = ACC_HOLD;
      cmd.mul_sel    = MUL_A1_S1;
      cmd.capture    = 1'b0;
      cmd.latch_node = 1'b0;
      cmd.finish     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.acc_op  = ACC_LOAD_X;
               cmd.mul_sel = MUL_A1_S1;
               cmd.capture = 1'b1;
               state_in    = ST_FB_ONE;
            end
         end
         ST_FB_ONE: begin
            cmd.acc_op  = ACC_SUB;
            cmd.mul_sel = MUL_A2_S2;
            state_in    = ST_FB_TWO;
         end
         ST_FB_TWO: begin
            cmd.acc_op  = ACC_SUB;
            cmd.mul_sel = MUL_B1_S1;
            state_in    = ST_NODE;
         end
         ST_NODE: begin
            cmd.acc_op     = ACC_LOAD_PROD;
            cmd.mul_sel    = MUL_B2_S2;
            cmd.latch_node = 1'b1;
            state_in       = ST_FF_ONE;
         end
         ST_FF_ONE: begin
            cmd.acc_op  = ACC_ADD;
            cmd.mul_sel = MUL_B0_P;
            state_in    = ST_FF_TWO;
         end
         ST_FF_TWO: begin
            cmd.acc_op = ACC_ADD;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            // Wait here until the output register is free or drains this cycle.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/bqd_datapath.sv =====
// Coefficient registers, delay words, shared multiplier, accumulator and output register.
`timescale 1ns / 1ps

module bqd_datapath import bqd_pkg::*; (
   input  logic                                clock,
   input  logic                                reset,
   input  bqd_cmd_type                         cmd,
   input  logic signed [DATA_WIDTH-1:0]        req_sample,
   input  logic                                req_last,
   input  logic                                csr_wr_en,
   input  logic        [CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic        [COEF_WIDTH-1:0]        csr_wdata,
   output logic signed [DATA_WIDTH-1:0]        rsp_sample,
   output logic                                rsp_last
);

   localparam logic signed [ACC_WIDTH-1:0] NODE_HALF =
      ACC_WIDTH'(64'sd1 <<< (COEF_FRAC - 1));
   localparam logic signed [ACC_WIDTH-1:0] OUT_HALF =
      ACC_WIDTH'(64'sd1 <<< (ACC_FRAC - 1));
   localparam logic signed [ACC_WIDTH-1:0] NODE_MAX =
      ACC_WIDTH'((64'sd1 <<< (DELAY_WIDTH - 1)) - 64'sd1);
   localparam logic signed [ACC_WIDTH-1:0] NODE_MIN = ~NODE_MAX;
   localparam logic signed [ACC_WIDTH-1:0] OUT_MAX =
      ACC_WIDTH'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
   localparam logic signed [ACC_WIDTH-1:0] OUT_MIN = ~OUT_MAX;
   localparam logic signed [COEF_WIDTH-1:0] UNITY =
      COEF_WIDTH'(64'sd1 <<< COEF_FRAC);

   logic signed [COEF_WIDTH-1:0]  fb_one_ff, fb_two_ff, ff_zero_ff, ff_one_ff, ff_two_ff;
   logic signed [DELAY_WIDTH-1:0] delay_one_ff, delay_two_ff;
   logic signed [DELAY_WIDTH-1:0] node_ff, node_in;
   logic signed [PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic signed [ACC_WIDTH-1:0]   acc_ff, acc_in;
   logic                          last_ff;
   logic signed [DATA_WIDTH-1:0]  out_sample_ff, out_sample_in;
   logic                          out_last_ff;

   logic signed [COEF_WIDTH-1:0]  mul_coef;
   logic signed [DELAY_WIDTH-1:0] mul_data;
   logic signed [ACC_WIDTH-1:0]   prod_ext;
   logic signed [ACC_WIDTH-1:0]   x_aligned;
   logic signed [ACC_WIDTH-1:0]   node_round, node_shift;
   logic signed [ACC_WIDTH-1:0]   out_round, out_shift;

   // Coefficient registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fb_one_ff  <= '0;
         fb_two_ff  <= '0;
         ff_zero_ff <= UNITY;
         ff_one_ff  <= '0;
         ff_two_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_FB_COEF_ONE:  fb_one_ff  <= csr_wdata;
            CSR_FB_COEF_TWO:  fb_two_ff  <= csr_wdata;
            CSR_FF_COEF_ZERO: ff_zero_ff <= csr_wdata;
            CSR_FF_COEF_ONE:  ff_one_ff  <= csr_wdata;
            CSR_FF_COEF_TWO:  ff_two_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (cmd.mul_sel)
         MUL_A1_S1: begin mul_coef = fb_one_ff;  mul_data = delay_one_ff; end
         MUL_A2_S2: begin mul_coef = fb_two_ff;  mul_data = delay_two_ff; end
         MUL_B1_S1: begin mul_coef = ff_one_ff;  mul_data = delay_one_ff; end
         MUL_B2_S2: begin mul_coef = ff_two_ff;  mul_data = delay_two_ff; end
         MUL_B0_P:  begin mul_coef = ff_zero_ff; mul_data = node_ff;      end
         default:   begin mul_coef = fb_one_ff;  mul_data = delay_one_ff; end
      endcase
   end

   assign prod_in  = mul_coef * mul_data;
   assign prod_ext = {{(ACC_WIDTH - PROD_WIDTH){prod_ff[PROD_WIDTH-1]}}, prod_ff};
   assign x_aligned = {{(ACC_WIDTH - DATA_WIDTH - ACC_FRAC){req_sample[DATA_WIDTH-1]}},
                       req_sample, {ACC_FRAC{1'b0}}};

   always_comb begin
      case (cmd.acc_op)
         ACC_HOLD:      acc_in = acc_ff;
         ACC_LOAD_X:    acc_in = x_aligned;
         ACC_SUB:       acc_in = acc_ff - prod_ext;
         ACC_ADD:       acc_in = acc_ff + prod_ext;
         ACC_LOAD_PROD: acc_in = prod_ext;
         default:       acc_in = acc_ff;
      endcase
   end

   // Feedback node: round half up to the delay scale, then clamp to the delay range.
   assign node_round = acc_ff + NODE_HALF;
   assign node_shift = node_round >>> COEF_FRAC;
   always_comb begin
      if (node_shift > NODE_MAX) begin
         node_in = NODE_MAX[DELAY_WIDTH-1:0];
      end else if (node_shift < NODE_MIN) begin
         node_in = NODE_MIN[DELAY_WIDTH-1:0];
      end else begin
         node_in = node_shift[DELAY_WIDTH-1:0];
      end
   end

   // Output: round half up to an integer, then clamp to the sample range.
   assign out_round = acc_ff + OUT_HALF;
   assign out_shift = out_round >>> ACC_FRAC;
   always_comb begin
      if (out_shift > OUT_MAX) begin
         out_sample_in = OUT_MAX[DATA_WIDTH-1:0];
      end else if (out_shift < OUT_MIN) begin
         out_sample_in = OUT_MIN[DATA_WIDTH-1:0];
      end else begin
         out_sample_in = out_shift[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (cmd.capture) begin
         last_ff <= req_last;
      end
      if (cmd.latch_node) begin
         node_ff <= node_in;
      end
      if (cmd.finish) begin
         out_sample_ff <= out_sample_in;
         out_last_ff   <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_one_ff <= '0;
         delay_two_ff <= '0;
      end else if (cmd.finish) begin
         delay_two_ff <= delay_one_ff;
         delay_one_ff <= node_ff;
      end
   end

   assign rsp_sample = out_sample_ff;
   assign rsp_last   = out_last_ff;

endmodule

// ===== hw/rtl/biquad_direct_form_two.sv =====
// Top level of the second-order direct form II IIR filter.
`timescale 1ns / 1ps

// Usage: samples arrive on the req channel (sample_in, last_in) and filtered
// samples leave on the rsp channel (sample_out, last_out); a transfer happens
// at a rising clock edge where valid and ready are both high. The five Q3.14
// coefficients are written through csr_wr_en, csr_index and csr_wdata while
// the filter is idle; indexes past the last register are ignored.
// After the input transfer the sequencer runs the two feedback products, the
// node rounding, the two feedforward products and the final rounding step
// before the result is valid. One multiplier is shared by the five products
// of a sample, so a new sample is taken only once the previous one is done.
// Reset clears both delay words, sets a1, a2, b1 and b2 to zero and b0 to
// unity, and empties the output register.
// When the receiver stalls, the finished result waits in the output register.
// One further sample may be taken and processed meanwhile; its result and
// the delay update are held back until the output register frees up.
module biquad_direct_form_two import bqd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   bqd_req_if.sink                    req,
   bqd_rsp_if.source                  rsp,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]      csr_wdata
);

   bqd_cmd_type cmd;
   logic        req_ready;
   logic        rsp_valid;

   bqd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   bqd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_sample (req.sample_in),
      .req_last   (req.last_in),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_sample (rsp.sample_out),
      .rsp_last   (rsp.last_out)
   );

   assign req.ready = req_ready;
   assign rsp.valid = rsp_valid;

   // A sample transfer starts a multi-cycle sequence, so ready must drop next cycle.
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req_ready) |=> !req_ready)
      else $error("input accepted while a sample is still in progress");

   // The output register is only loaded when it is empty or being drained.
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || rsp.ready))
      else $error("result written over an untaken result");

   // A new result appears only as the outcome of a finish step.
   a_valid_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.finish))
      else $error("result valid without a finished computation");

endmodule
